// ===== rtl/hsv_to_rgb_converter_macros.svh =====
// Assertion helpers used by the top-level RTL file.
`ifndef HSV_TO_RGB_CONVERTER_MACROS_SVH
`define HSV_TO_RGB_CONVERTER_MACROS_SVH

// Check cons in the same cycle as ante.
`define HSVC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a sequence (may start with a fixed delay) that follows ante.
`define HSVC_ASSERT_SEQ(label, ante, seq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> seq) \
        else $error(msg);

`endif

// ===== rtl/hsvc_pkg.sv =====
package hsvc_pkg;

    localparam int HUE_W    = 9;
    localparam int CHAN_W   = 8;
    localparam int SECTOR_W = 4;
    localparam int K_W      = 6;
    localparam int WSPAN_W  = 14;
    localparam int XSPAN_W  = WSPAN_W + CHAN_W;
    localparam int XFULL_W  = 2 * CHAN_W;

    localparam int SECTOR_SPAN = 60;
    localparam int FULL_SCALE  = 255;
    localparam int SPAN_SCALE  = SECTOR_SPAN * FULL_SCALE;
    localparam int SECTOR_MAX  = ((1 << HUE_W) - 1) / SECTOR_SPAN;

    localparam int LATENCY = 5;

    localparam int RECIP_SPAN_SHIFT = 36;
    localparam int RECIP_SPAN_W     = 23;
    localparam logic [63:0] RECIP_SPAN_WIDE =
        ((64'd1 << RECIP_SPAN_SHIFT) + 64'(SPAN_SCALE) - 64'd1) / 64'(SPAN_SCALE);
    localparam logic [RECIP_SPAN_W-1:0] RECIP_SPAN = RECIP_SPAN_WIDE[RECIP_SPAN_W-1:0];

    localparam int RECIP_FULL_SHIFT = 24;
    localparam int RECIP_FULL_W     = 17;
    localparam logic [63:0] RECIP_FULL_WIDE =
        ((64'd1 << RECIP_FULL_SHIFT) + 64'(FULL_SCALE) - 64'd1) / 64'(FULL_SCALE);
    localparam logic [RECIP_FULL_W-1:0] RECIP_FULL = RECIP_FULL_WIDE[RECIP_FULL_W-1:0];

    localparam logic [SECTOR_W-1:0] SEC_RED     = 4'd0;
    localparam logic [SECTOR_W-1:0] SEC_YELLOW  = 4'd1;
    localparam logic [SECTOR_W-1:0] SEC_GREEN   = 4'd2;
    localparam logic [SECTOR_W-1:0] SEC_CYAN    = 4'd3;
    localparam logic [SECTOR_W-1:0] SEC_BLUE    = 4'd4;

    typedef struct packed {
        logic [SECTOR_W-1:0] sector;
        logic [K_W-1:0]      k;
        logic [CHAN_W-1:0]   sat;
        logic [CHAN_W-1:0]   val;
    } sec_item_t;

    typedef struct packed {
        logic [SECTOR_W-1:0] sector;
        logic [CHAN_W-1:0]   val;
        logic [XSPAN_W-1:0]  xq;
        logic [XSPAN_W-1:0]  xt;
        logic [XFULL_W-1:0]  xp;
    } prod_item_t;

    typedef struct packed {
        logic [SECTOR_W-1:0] sector;
        logic [CHAN_W-1:0]   val;
        logic [CHAN_W-1:0]   q;
        logic [CHAN_W-1:0]   t;
        logic [CHAN_W-1:0]   p;
    } level_item_t;

endpackage

// ===== rtl/hsvc_sector.sv =====
module hsvc_sector (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic [hsvc_pkg::HUE_W-1:0]  hue,
    input  logic [hsvc_pkg::CHAN_W-1:0] saturation,
    input  logic [hsvc_pkg::CHAN_W-1:0] brightness,
    output logic                        out_valid,
    output hsvc_pkg::sec_item_t         out_item
);
    import hsvc_pkg::*;

    logic                valid_reg;
    sec_item_t           item_reg;
    sec_item_t           item_next;
    logic [SECTOR_W-1:0] sector;
    logic [HUE_W-1:0]    base;

    always_comb
    begin
        sector = '0;
        base   = '0;
        for (int i = 1; i <= SECTOR_MAX; i++)
        begin
            if (hue >= HUE_W'(i * SECTOR_SPAN))
            begin
                sector = SECTOR_W'(i);
                base   = HUE_W'(i * SECTOR_SPAN);
            end
        end
        item_next.sector = sector;
        item_next.k      = K_W'(hue - base);
        item_next.sat    = saturation;
        item_next.val    = brightness;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

// ===== rtl/hsvc_weight.sv =====
module hsvc_weight (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  hsvc_pkg::sec_item_t in_item,
    output logic                out_valid,
    output hsvc_pkg::prod_item_t out_item
);
    import hsvc_pkg::*;

    logic                valid1_reg;
    logic                valid2_reg;
    logic [SECTOR_W-1:0] sector_reg;
    logic [CHAN_W-1:0]   val_reg;
    logic [WSPAN_W-1:0]  wq_reg;
    logic [WSPAN_W-1:0]  wt_reg;
    logic [CHAN_W-1:0]   wp_reg;
    logic [WSPAN_W-1:0]  wq_next;
    logic [WSPAN_W-1:0]  wt_next;
    logic [CHAN_W-1:0]   wp_next;
    logic [K_W-1:0]      k_rev;
    prod_item_t          item_reg;
    prod_item_t          item_next;

    always_comb
    begin
        k_rev   = K_W'(SECTOR_SPAN) - in_item.k;
        wq_next = WSPAN_W'(SPAN_SCALE) - WSPAN_W'(in_item.sat) * WSPAN_W'(in_item.k);
        wt_next = WSPAN_W'(SPAN_SCALE) - WSPAN_W'(in_item.sat) * WSPAN_W'(k_rev);
        wp_next = CHAN_W'(FULL_SCALE) - in_item.sat;
    end

    always_comb
    begin
        item_next.sector = sector_reg;
        item_next.val    = val_reg;
        item_next.xq     = XSPAN_W'(val_reg) * XSPAN_W'(wq_reg);
        item_next.xt     = XSPAN_W'(val_reg) * XSPAN_W'(wt_reg);
        item_next.xp     = XFULL_W'(val_reg) * XFULL_W'(wp_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
        end
        else
        begin
            valid1_reg <= in_valid;
            valid2_reg <= valid1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            sector_reg <= in_item.sector;
            val_reg    <= in_item.val;
            wq_reg     <= wq_next;
            wt_reg     <= wt_next;
            wp_reg     <= wp_next;
        end
        if (valid1_reg)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid2_reg;
    assign out_item  = item_reg;

endmodule

// ===== rtl/hsvc_divide.sv =====
module hsvc_divide (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  hsvc_pkg::prod_item_t  in_item,
    output logic                  out_valid,
    output hsvc_pkg::level_item_t out_item
);
    import hsvc_pkg::*;

    localparam int PQ_W = XSPAN_W + RECIP_SPAN_W;
    localparam int PP_W = XFULL_W + RECIP_FULL_W;

    logic              valid_reg;
    level_item_t       item_reg;
    level_item_t       item_next;
    logic [PQ_W-1:0]   prod_q;
    logic [PQ_W-1:0]   prod_t;
    logic [PP_W-1:0]   prod_p;

    always_comb
    begin
        prod_q = PQ_W'(in_item.xq) * PQ_W'(RECIP_SPAN);
        prod_t = PQ_W'(in_item.xt) * PQ_W'(RECIP_SPAN);
        prod_p = PP_W'(in_item.xp) * PP_W'(RECIP_FULL);
        item_next.sector = in_item.sector;
        item_next.val    = in_item.val;
        item_next.q      = prod_q[RECIP_SPAN_SHIFT +: CHAN_W];
        item_next.t      = prod_t[RECIP_SPAN_SHIFT +: CHAN_W];
        item_next.p      = prod_p[RECIP_FULL_SHIFT +: CHAN_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

// ===== rtl/hsv_to_rgb_converter.sv =====
// Channel  | Signals                           | Handshake
// ---------+-----------------------------------+------------------------------
// pixel in | hue, saturation, brightness       | start high, busy low
// rgb out  | red, green, blue                  | done high for one cycle
//
// One transaction enters every cycle; busy stays low.
// Each result appears in order, set by a five-register pipeline: sector
// split, weights, value products, reciprocal scaling, channel routing.
// Reset clears the valid bits only; no results follow reset until new input.
// The receiver cannot stall, so nothing is ever held back.
`include "hsv_to_rgb_converter_macros.svh"

module hsv_to_rgb_converter (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [hsvc_pkg::HUE_W-1:0]  hue,
    input  logic [hsvc_pkg::CHAN_W-1:0] saturation,
    input  logic [hsvc_pkg::CHAN_W-1:0] brightness,
    output logic                        done,
    output logic [hsvc_pkg::CHAN_W-1:0] red,
    output logic [hsvc_pkg::CHAN_W-1:0] green,
    output logic [hsvc_pkg::CHAN_W-1:0] blue
);
    import hsvc_pkg::*;

    logic              accept;
    logic              sec_valid;
    sec_item_t         sec_item;
    logic              prod_valid;
    prod_item_t        prod_item;
    logic              lvl_valid;
    level_item_t       lvl_item;
    logic              done_reg;
    logic [CHAN_W-1:0] red_reg;
    logic [CHAN_W-1:0] green_reg;
    logic [CHAN_W-1:0] blue_reg;
    logic [CHAN_W-1:0] red_next;
    logic [CHAN_W-1:0] green_next;
    logic [CHAN_W-1:0] blue_next;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    hsvc_sector u_sector (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (accept),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness),
        .out_valid  (sec_valid),
        .out_item   (sec_item)
    );

    hsvc_weight u_weight (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sec_valid),
        .in_item   (sec_item),
        .out_valid (prod_valid),
        .out_item  (prod_item)
    );

    hsvc_divide u_divide (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (prod_valid),
        .in_item   (prod_item),
        .out_valid (lvl_valid),
        .out_item  (lvl_item)
    );

    always_comb
    begin
        case (lvl_item.sector)
            SEC_RED:
            begin
                red_next   = lvl_item.val;
                green_next = lvl_item.t;
                blue_next  = lvl_item.p;
            end
            SEC_YELLOW:
            begin
                red_next   = lvl_item.q;
                green_next = lvl_item.val;
                blue_next  = lvl_item.p;
            end
            SEC_GREEN:
            begin
                red_next   = lvl_item.p;
                green_next = lvl_item.val;
                blue_next  = lvl_item.t;
            end
            SEC_CYAN:
            begin
                red_next   = lvl_item.p;
                green_next = lvl_item.q;
                blue_next  = lvl_item.val;
            end
            SEC_BLUE:
            begin
                red_next   = lvl_item.t;
                green_next = lvl_item.p;
                blue_next  = lvl_item.val;
            end
            default:
            begin
                red_next   = lvl_item.val;
                green_next = lvl_item.p;
                blue_next  = lvl_item.q;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= lvl_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (lvl_valid)
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign done  = done_reg;
    assign red   = red_reg;
    assign green = green_reg;
    assign blue  = blue_reg;

    `HSVC_ASSERT_SEQ(a_latency, accept, ##LATENCY done, "result missing after latency")
    `HSVC_ASSERT_SEQ(a_gray, accept && (saturation == '0), ##LATENCY ((red == $past(brightness, LATENCY)) && (green == $past(brightness, LATENCY)) && (blue == $past(brightness, LATENCY))), "zero saturation not gray")
    `HSVC_ASSERT_SAME(a_value_channel, done, (red == $past(brightness, LATENCY)) || (green == $past(brightness, LATENCY)) || (blue == $past(brightness, LATENCY)), "no channel carries value")

endmodule
